/* rtl/tdma_slot_phase_frame_counter_unit_assert.svh */
// Assertion macros for the slot timer RTL.
// Expects i_clk and i_rst_n in the scope of the module that uses them.
`ifndef TDMA_SLOT_PHASE_FRAME_COUNTER_UNIT_ASSERT_SVH
`define TDMA_SLOT_PHASE_FRAME_COUNTER_UNIT_ASSERT_SVH

// Condition that must hold at every clock edge out of reset
`define TSPF_ASSERT_ALWAYS(lbl, expr) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) \
        else $error("slot timer assertion failed");

// Condition that must hold in the cycle after a trigger
`define TSPF_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("slot timer assertion failed");

`endif

/* rtl/tspf_pkg.sv */
// Shared types and constants for the TDMA slot/phase/frame counter.
// No dependencies; used by every other RTL file except the assertion header.
package tspf_pkg;

    // field widths
    localparam int CNT_W      = 23;
    localparam int ADJ1_W     = 12;
    localparam int ADJ10_W    = 8;
    localparam int ADJ100_W   = 8;
    localparam int DELTA_W    = 13;
    localparam int SOFF_W     = 13;
    localparam int POFF_W     = 16;
    localparam int PHASE_W    = 11;
    localparam int SLOT_W     = 12;
    localparam int FRAME_W    = 31;
    localparam int GPS_W      = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 23;

    localparam logic [FRAME_W-1:0] FRAME_MAX = '1;

    // period reset values, in 48 kHz ticks
    localparam logic [CNT_W-1:0] PER_ONE_RST     = 23'd48000;
    localparam logic [CNT_W-1:0] PER_TEN_RST     = 23'd480000;
    localparam logic [CNT_W-1:0] PER_HUNDRED_RST = 23'd4800000;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ADJ_ONE     = 3'd0,
        CFG_ADJ_TEN     = 3'd1,
        CFG_ADJ_HUNDRED = 3'd2,
        CFG_PER_ONE     = 3'd3,
        CFG_PER_TEN     = 3'd4,
        CFG_PER_HUNDRED = 3'd5
    } t_cfg_idx;

    // one classified tick, front to back
    typedef struct packed {
        logic                      counting;
        logic                      sync;
        logic signed [DELTA_W-1:0] delta;    // phase step: 1 minus corrections
        logic signed [SOFF_W-1:0]  soff;
        logic signed [POFF_W-1:0]  poff;
        logic [GPS_W-1:0]          gps;      // GPS tick count after this tick
    } t_op;

endpackage

/* rtl/tspf_if.sv */
// Valid/ready channel interfaces for tick beats and result beats.
// Depends on tspf_pkg for field widths.
interface tspf_tick_if;
    logic                                      valid;
    logic                                      ready;
    logic                                      high_freq;
    logic                                      rtc_handover;
    logic                                      tim_handover;
    logic                                      gps_protect;
    logic                                      sync_pending;
    logic signed [tspf_pkg::SOFF_W-1:0]        slot_offset;
    logic signed [tspf_pkg::POFF_W-1:0]        phase_offset;

    modport source (
        output valid, high_freq, rtc_handover, tim_handover, gps_protect,
               sync_pending, slot_offset, phase_offset,
        input  ready
    );
    modport sink (
        input  valid, high_freq, rtc_handover, tim_handover, gps_protect,
               sync_pending, slot_offset, phase_offset,
        output ready
    );
endinterface

interface tspf_res_if;
    logic                           valid;
    logic                           ready;
    logic [tspf_pkg::PHASE_W-1:0]   phase;
    logic [tspf_pkg::SLOT_W-1:0]    slot;
    logic [tspf_pkg::FRAME_W-1:0]   frame;
    logic [tspf_pkg::GPS_W-1:0]     gps_ticks;
    logic                           sync_taken;

    modport source (
        output valid, phase, slot, frame, gps_ticks, sync_taken,
        input  ready
    );
    modport sink (
        input  valid, phase, slot, frame, gps_ticks, sync_taken,
        output ready
    );
endinterface

/* rtl/tspf_queue.sv */
// Two-entry queue of classified ticks between front and back end.
// Depends on tspf_pkg for the t_op type.
module tspf_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  tspf_pkg::t_op i_op,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_empty,
    output tspf_pkg::t_op o_op
);

    localparam int DEPTH = 2;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    tspf_pkg::t_op    r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [CNT_W-1:0] r_cnt;

    assign o_full  = (r_cnt == CNT_W'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_op    = r_mem[r_rd];

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + PTR_W'(1);
            end
            if (i_pop) begin
                r_rd <= r_rd + PTR_W'(1);
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + CNT_W'(1);
                2'b01:   r_cnt <= r_cnt - CNT_W'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_op;
        end
    end

endmodule

/* rtl/tspf_front.sv */
// Front end: configuration registers, correction period counters, GPS tick
// count, and classification of each tick beat. Depends on tspf_pkg, tspf_if.
module tspf_front (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [tspf_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [tspf_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    tspf_tick_if.sink                           i_tick,
    output logic                                o_push,
    output tspf_pkg::t_op                       o_op,
    input  logic                                i_full
);

    logic signed [tspf_pkg::ADJ1_W-1:0]   r_adj_one;
    logic signed [tspf_pkg::ADJ10_W-1:0]  r_adj_ten;
    logic signed [tspf_pkg::ADJ100_W-1:0] r_adj_hundred;
    logic [tspf_pkg::CNT_W-1:0]           r_per_one;
    logic [tspf_pkg::CNT_W-1:0]           r_per_ten;
    logic [tspf_pkg::CNT_W-1:0]           r_per_hundred;
    logic [tspf_pkg::CNT_W-1:0]           r_cnt_one;
    logic [tspf_pkg::CNT_W-1:0]           r_cnt_ten;
    logic [tspf_pkg::CNT_W-1:0]           r_cnt_hundred;
    logic [tspf_pkg::GPS_W-1:0]           r_gps;

    logic [tspf_pkg::CNT_W-1:0]           w_inc_one;
    logic [tspf_pkg::CNT_W-1:0]           w_inc_ten;
    logic [tspf_pkg::CNT_W-1:0]           w_inc_hundred;
    logic                                 w_fire_one;
    logic                                 w_fire_ten;
    logic                                 w_fire_hundred;
    logic                                 w_counting;
    logic                                 w_sync;
    logic                                 w_gps_inc;
    logic [tspf_pkg::GPS_W-1:0]           w_gps_next;
    logic signed [tspf_pkg::DELTA_W-1:0]  w_adj_sum;

    assign i_tick.ready = !i_full;
    assign o_push       = i_tick.valid && !i_full;

    // counting enable and sync classification
    assign w_counting = i_tick.high_freq ? !i_tick.rtc_handover : i_tick.tim_handover;
    assign w_sync     = w_counting && i_tick.high_freq && i_tick.sync_pending;
    assign w_gps_inc  = w_counting && i_tick.high_freq && i_tick.gps_protect;
    assign w_gps_next = w_gps_inc ? r_gps + tspf_pkg::GPS_W'(1) : r_gps;

    // period counters fire when the incremented count reaches the period
    assign w_inc_one      = r_cnt_one + tspf_pkg::CNT_W'(1);
    assign w_inc_ten      = r_cnt_ten + tspf_pkg::CNT_W'(1);
    assign w_inc_hundred  = r_cnt_hundred + tspf_pkg::CNT_W'(1);
    assign w_fire_one     = (w_inc_one >= r_per_one);
    assign w_fire_ten     = (w_inc_ten >= r_per_ten);
    assign w_fire_hundred = (w_inc_hundred >= r_per_hundred);

    // corrections are skipped while a sync is pending
    always_comb begin
        w_adj_sum = '0;
        if (!i_tick.sync_pending) begin
            if (w_fire_one) begin
                w_adj_sum = w_adj_sum + tspf_pkg::DELTA_W'(r_adj_one);
            end
            if (w_fire_ten) begin
                w_adj_sum = w_adj_sum + tspf_pkg::DELTA_W'(r_adj_ten);
            end
            if (w_fire_hundred) begin
                w_adj_sum = w_adj_sum + tspf_pkg::DELTA_W'(r_adj_hundred);
            end
        end
    end

    // classified beat toward the back end
    always_comb begin
        o_op.counting = w_counting;
        o_op.sync     = w_sync;
        o_op.delta    = tspf_pkg::DELTA_W'(1) - w_adj_sum;
        o_op.soff     = i_tick.slot_offset;
        o_op.poff     = i_tick.phase_offset;
        o_op.gps      = w_gps_next;
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_adj_one     <= '0;
            r_adj_ten     <= '0;
            r_adj_hundred <= '0;
            r_per_one     <= tspf_pkg::PER_ONE_RST;
            r_per_ten     <= tspf_pkg::PER_TEN_RST;
            r_per_hundred <= tspf_pkg::PER_HUNDRED_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                tspf_pkg::CFG_ADJ_ONE:     r_adj_one     <= i_cfg_data[tspf_pkg::ADJ1_W-1:0];
                tspf_pkg::CFG_ADJ_TEN:     r_adj_ten     <= i_cfg_data[tspf_pkg::ADJ10_W-1:0];
                tspf_pkg::CFG_ADJ_HUNDRED: r_adj_hundred <= i_cfg_data[tspf_pkg::ADJ100_W-1:0];
                tspf_pkg::CFG_PER_ONE:     r_per_one     <= i_cfg_data;
                tspf_pkg::CFG_PER_TEN:     r_per_ten     <= i_cfg_data;
                tspf_pkg::CFG_PER_HUNDRED: r_per_hundred <= i_cfg_data;
                default:                   r_per_one     <= r_per_one;
            endcase
        end
    end

    // counters advance on counting beats; a taken sync clears them
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt_one     <= '0;
            r_cnt_ten     <= '0;
            r_cnt_hundred <= '0;
            r_gps         <= '0;
        end else if (o_push && w_counting) begin
            r_gps <= w_gps_next;
            if (w_sync) begin
                r_cnt_one     <= '0;
                r_cnt_ten     <= '0;
                r_cnt_hundred <= '0;
            end else begin
                r_cnt_one     <= w_fire_one ? '0 : w_inc_one;
                r_cnt_ten     <= w_fire_ten ? '0 : w_inc_ten;
                r_cnt_hundred <= w_fire_hundred ? '0 : w_inc_hundred;
            end
        end
    end

endmodule

/* rtl/tspf_back.sv */
// Back end: phase/slot/frame state, fast increment path and a sequencer that
// normalizes with reciprocal-multiply floor division. Depends on tspf_pkg, tspf_if and the assertion header.
`include "tdma_slot_phase_frame_counter_unit_assert.svh"

module tspf_back #(
    parameter int PHASES = 1280,
    parameter int SLOTS  = 2250
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_empty,
    input  tspf_pkg::t_op i_op,
    output logic          o_pop,
    tspf_res_if.source    o_res
);

    localparam int PHASE_W = tspf_pkg::PHASE_W;
    localparam int SLOT_W  = tspf_pkg::SLOT_W;
    localparam int FRAME_W = tspf_pkg::FRAME_W;
    localparam int GPS_W   = tspf_pkg::GPS_W;
    localparam int POFF_W  = tspf_pkg::POFF_W;
    localparam int SOFF_W  = tspf_pkg::SOFF_W;

    // phase divider: x = phase + step lies in [-XNEG, XPOS]
    localparam int XNEG  = 2 ** (POFF_W - 1);
    localparam int XPOS  = PHASES - 1 + XNEG - 1;
    localparam int C1    = (XNEG + PHASES - 1) / PHASES;
    localparam int B1    = C1 * PHASES;
    localparam int XU_W  = $clog2(XPOS + B1 + 1);
    localparam int XS_W  = XU_W + 1;
    localparam int M1    = (2 ** XU_W) / PHASES;
    localparam int M1_W  = $clog2(M1 + 1);
    localparam int Q1_W  = M1_W + 1;
    localparam int P1_W  = XU_W + M1_W;

    // slot divider: y = slot + carry (or slot offset)
    localparam int SNEG  = 2 ** (SOFF_W - 1);
    localparam int SPOS  = SNEG - 1;
    localparam int QPOS1 = XPOS / PHASES;
    localparam int YNEG  = (C1 > SNEG) ? C1 : SNEG;
    localparam int YPOS  = SLOTS - 1 + ((QPOS1 > SPOS) ? QPOS1 : SPOS);
    localparam int C2    = (YNEG + SLOTS - 1) / SLOTS;
    localparam int B2    = C2 * SLOTS;
    localparam int YU_W  = $clog2(YPOS + B2 + 1);
    localparam int YS_W  = YU_W + 1;
    localparam int M2    = (2 ** YU_W) / SLOTS;
    localparam int M2_W  = $clog2(M2 + 1);
    localparam int Q2_W  = M2_W + 1;
    localparam int P2_W  = YU_W + M2_W;
    localparam int FS_W  = FRAME_W + 2;

    typedef enum logic [2:0] {
        ST_IDLE, ST_PA, ST_PB, ST_SA, ST_SB, ST_SOFF, ST_EMIT
    } t_state;

    typedef enum logic [1:0] {
        STG_MAIN, STG_SOFF, STG_POFF
    } t_stage;

    t_state                    r_state, n_state;
    t_stage                    r_stage, n_stage;
    logic [PHASE_W-1:0]        r_phase, n_phase;
    logic [SLOT_W-1:0]         r_slot, n_slot;
    logic [FRAME_W-1:0]        r_frame, n_frame;
    logic signed [POFF_W-1:0]  r_delta, n_delta;
    logic signed [SOFF_W-1:0]  r_soff, n_soff;
    logic signed [POFF_W-1:0]  r_poff, n_poff;
    logic [GPS_W-1:0]          r_gps, n_gps;
    logic                      r_sync, n_sync;
    logic [XU_W-1:0]           r_xu, n_xu;
    logic [M1_W-1:0]           r_q0, n_q0;
    logic signed [YS_W-1:0]    r_y, n_y;
    logic [YU_W-1:0]           r_yu, n_yu;
    logic [M2_W-1:0]           r_q0s, n_q0s;
    logic                      r_out_valid, n_out_valid;
    logic [PHASE_W-1:0]        r_o_phase, n_o_phase;
    logic [SLOT_W-1:0]         r_o_slot, n_o_slot;
    logic [FRAME_W-1:0]        r_o_frame, n_o_frame;
    logic [GPS_W-1:0]          r_o_gps, n_o_gps;
    logic                      r_o_taken, n_o_taken;

    logic                      w_can_load;
    logic                      w_load;
    logic [PHASE_W-1:0]        w_ld_phase;
    logic [SLOT_W-1:0]         w_ld_slot;
    logic [FRAME_W-1:0]        w_ld_frame;
    logic [GPS_W-1:0]          w_ld_gps;
    logic                      w_ld_taken;

    logic [PHASE_W-1:0]        w_ph_inc;
    logic [SLOT_W-1:0]         w_sl_inc;
    logic [PHASE_W-1:0]        w_fast_phase;
    logic [SLOT_W-1:0]         w_fast_slot;
    logic [FRAME_W-1:0]        w_fast_frame;

    logic signed [XS_W-1:0]    w_x;
    logic [XU_W-1:0]           w_xu;
    logic [P1_W-1:0]           w_prod1;
    logic [XU_W-1:0]           w_rem1;
    logic                      w_corr1;
    logic [M1_W-1:0]           w_q1u;
    logic signed [Q1_W-1:0]    w_q1;
    logic [PHASE_W-1:0]        w_ph_new;
    logic signed [YS_W-1:0]    w_y;

    logic [YU_W-1:0]           w_yu;
    logic [P2_W-1:0]           w_prod2;
    logic [YU_W-1:0]           w_rem2;
    logic                      w_corr2;
    logic [M2_W-1:0]           w_q2u;
    logic signed [Q2_W-1:0]    w_q2;
    logic [SLOT_W-1:0]         w_sl_new;
    logic signed [FS_W-1:0]    w_fsum;

    assign w_can_load = !r_out_valid || o_res.ready;

    assign o_res.valid      = r_out_valid;
    assign o_res.phase      = r_o_phase;
    assign o_res.slot       = r_o_slot;
    assign o_res.frame      = r_o_frame;
    assign o_res.gps_ticks  = r_o_gps;
    assign o_res.sync_taken = r_o_taken;

    // fast path: step of +1 with single carries
    always_comb begin
        w_ph_inc     = r_phase + PHASE_W'(1);
        w_sl_inc     = r_slot + SLOT_W'(1);
        w_fast_phase = w_ph_inc;
        w_fast_slot  = r_slot;
        w_fast_frame = r_frame;
        if (w_ph_inc == PHASE_W'(PHASES)) begin
            w_fast_phase = '0;
            w_fast_slot  = w_sl_inc;
            if (w_sl_inc == SLOT_W'(SLOTS)) begin
                w_fast_slot = '0;
                if (r_frame != tspf_pkg::FRAME_MAX) begin
                    w_fast_frame = r_frame + FRAME_W'(1);
                end
            end
        end
    end

    // phase divide, first cycle: offset to non-negative, multiply by reciprocal
    assign w_x     = XS_W'(signed'({1'b0, r_phase})) + XS_W'(r_delta);
    assign w_xu    = XU_W'(w_x + XS_W'(B1));
    assign w_prod1 = P1_W'(w_xu) * P1_W'(M1);

    // phase divide, second cycle: remainder, one correction, carry into slot
    assign w_rem1   = r_xu - XU_W'(XU_W'(r_q0) * XU_W'(PHASES));
    assign w_corr1  = (w_rem1 >= XU_W'(PHASES));
    assign w_q1u    = r_q0 + M1_W'(w_corr1);
    assign w_q1     = Q1_W'({1'b0, w_q1u}) - Q1_W'(C1);
    assign w_ph_new = PHASE_W'(w_corr1 ? w_rem1 - XU_W'(PHASES) : w_rem1);
    assign w_y      = YS_W'(signed'({1'b0, r_slot})) + YS_W'(w_q1);

    // slot divide, first cycle
    assign w_yu    = YU_W'(r_y + YS_W'(B2));
    assign w_prod2 = P2_W'(w_yu) * P2_W'(M2);

    // slot divide, second cycle: remainder and frame carry
    assign w_rem2   = r_yu - YU_W'(YU_W'(r_q0s) * YU_W'(SLOTS));
    assign w_corr2  = (w_rem2 >= YU_W'(SLOTS));
    assign w_q2u    = r_q0s + M2_W'(w_corr2);
    assign w_q2     = Q2_W'({1'b0, w_q2u}) - Q2_W'(C2);
    assign w_sl_new = SLOT_W'(w_corr2 ? w_rem2 - YU_W'(SLOTS) : w_rem2);
    assign w_fsum   = FS_W'(signed'({1'b0, r_frame})) + FS_W'(w_q2);

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_stage     = r_stage;
        n_phase     = r_phase;
        n_slot      = r_slot;
        n_frame     = r_frame;
        n_delta     = r_delta;
        n_soff      = r_soff;
        n_poff      = r_poff;
        n_gps       = r_gps;
        n_sync      = r_sync;
        n_xu        = r_xu;
        n_q0        = r_q0;
        n_y         = r_y;
        n_yu        = r_yu;
        n_q0s       = r_q0s;
        o_pop       = 1'b0;
        w_load      = 1'b0;
        w_ld_phase  = r_phase;
        w_ld_slot   = r_slot;
        w_ld_frame  = r_frame;
        w_ld_gps    = r_gps;
        w_ld_taken  = 1'b0;

        case (r_state)
            ST_IDLE: begin
                if (!i_empty && w_can_load) begin
                    o_pop = 1'b1;
                    if (!i_op.counting) begin
                        w_load   = 1'b1;
                        w_ld_gps = i_op.gps;
                    end else if (!i_op.sync && i_op.delta == tspf_pkg::DELTA_W'(1)) begin
                        n_phase    = w_fast_phase;
                        n_slot     = w_fast_slot;
                        n_frame    = w_fast_frame;
                        w_load     = 1'b1;
                        w_ld_phase = w_fast_phase;
                        w_ld_slot  = w_fast_slot;
                        w_ld_frame = w_fast_frame;
                        w_ld_gps   = i_op.gps;
                    end else begin
                        n_delta = POFF_W'(i_op.delta);
                        n_soff  = i_op.soff;
                        n_poff  = i_op.poff;
                        n_gps   = i_op.gps;
                        n_sync  = i_op.sync;
                        n_stage = STG_MAIN;
                        n_state = ST_PA;
                    end
                end
            end
            ST_PA: begin
                n_xu    = w_xu;
                n_q0    = M1_W'(w_prod1[P1_W-1:XU_W]);
                n_state = ST_PB;
            end
            ST_PB: begin
                n_phase = w_ph_new;
                n_y     = w_y;
                n_state = ST_SA;
            end
            ST_SOFF: begin
                n_y     = YS_W'(signed'({1'b0, r_slot})) + YS_W'(r_soff);
                n_state = ST_SA;
            end
            ST_SA: begin
                n_yu    = w_yu;
                n_q0s   = M2_W'(w_prod2[P2_W-1:YU_W]);
                n_state = ST_SB;
            end
            ST_SB: begin
                // negative frame clears all three fields; top end saturates
                if (w_fsum[FS_W-1]) begin
                    n_frame = '0;
                    n_slot  = '0;
                    n_phase = '0;
                end else if (w_fsum[FRAME_W]) begin
                    n_frame = tspf_pkg::FRAME_MAX;
                    n_slot  = w_sl_new;
                end else begin
                    n_frame = w_fsum[FRAME_W-1:0];
                    n_slot  = w_sl_new;
                end
                if (r_sync && r_stage == STG_MAIN) begin
                    n_stage = STG_SOFF;
                    n_state = ST_SOFF;
                end else if (r_sync && r_stage == STG_SOFF) begin
                    n_stage = STG_POFF;
                    n_delta = r_poff;
                    n_state = ST_PA;
                end else begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (w_can_load) begin
                    w_load     = 1'b1;
                    w_ld_taken = r_sync;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        // output register
        n_out_valid = r_out_valid;
        n_o_phase   = r_o_phase;
        n_o_slot    = r_o_slot;
        n_o_frame   = r_o_frame;
        n_o_gps     = r_o_gps;
        n_o_taken   = r_o_taken;
        if (w_load) begin
            n_out_valid = 1'b1;
            n_o_phase   = w_ld_phase;
            n_o_slot    = w_ld_slot;
            n_o_frame   = w_ld_frame;
            n_o_gps     = w_ld_gps;
            n_o_taken   = w_ld_taken;
        end else if (o_res.ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_stage     <= STG_MAIN;
            r_phase     <= '0;
            r_slot      <= '0;
            r_frame     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_stage     <= n_stage;
            r_phase     <= n_phase;
            r_slot      <= n_slot;
            r_frame     <= n_frame;
            r_out_valid <= n_out_valid;
        end
        r_delta   <= n_delta;
        r_soff    <= n_soff;
        r_poff    <= n_poff;
        r_gps     <= n_gps;
        r_sync    <= n_sync;
        r_xu      <= n_xu;
        r_q0      <= n_q0;
        r_y       <= n_y;
        r_yu      <= n_yu;
        r_q0s     <= n_q0s;
        r_o_phase <= n_o_phase;
        r_o_slot  <= n_o_slot;
        r_o_frame <= n_o_frame;
        r_o_gps   <= n_o_gps;
        r_o_taken <= n_o_taken;
    end

    // state stays normalized through every step of the sequencer
    `TSPF_ASSERT_ALWAYS(a_phase_range, r_phase < PHASE_W'(PHASES))
    `TSPF_ASSERT_ALWAYS(a_slot_range, r_slot < SLOT_W'(SLOTS))
    // the phase divide always goes on from ST_PA to ST_PB
    `TSPF_ASSERT_NEXT(a_pa_then_pb, r_state == ST_PA, r_state == ST_PB)
    // a finished result waits while the output register is held
    `TSPF_ASSERT_NEXT(a_emit_holds, (r_state == ST_EMIT) && r_out_valid && !o_res.ready, r_state == ST_EMIT)

endmodule

/* rtl/tdma_slot_phase_frame_counter_unit.sv */
// Top level of the TDMA slot/phase/frame counter.
// Depends on tspf_pkg, tspf_if, tspf_front, tspf_queue and tspf_back.

// Each tick beat advances a phase (0..PHASES_PER_SLOT-1) that carries into a
// slot (0..SLOTS_PER_FRAME-1) and a saturating frame count, applies the one-,
// ten- and hundred-second drift corrections and, in high-frequency mode,
// a pending GPS slot/phase sync; every tick beat returns one result beat with
// the values after that tick. The front end keeps the period counters and GPS
// tick count and classifies each tick in its accept cycle; a two-entry queue
// feeds the back end, which owns phase, slot and frame. A plain tick (no
// correction, no sync) or a non-counting tick ends in ST_IDLE, so the block
// runs at one tick per clock while o_res.ready is high. A correction tick runs
// ST_PA, ST_PB, ST_SA, ST_SB, ST_EMIT; a sync tick adds ST_SOFF, ST_SA, ST_SB
// (slot offset) and ST_PA to ST_SB (phase offset). Each divide by the phase
// or slot count is a reciprocal multiply, then the remainder and one
// correction. Configuration is written through i_cfg_we/i_cfg_idx/i_cfg_data
// only while the block holds no tick in flight; the block does not enforce it.
module tdma_slot_phase_frame_counter_unit #(
    parameter int PHASES_PER_SLOT = 1280,
    parameter int SLOTS_PER_FRAME = 2250
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [tspf_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [tspf_pkg::CFG_DATA_W-1:0] i_cfg_data,
    tspf_tick_if.sink                       i_tick,
    tspf_res_if.source                      o_res
);

    logic          w_push;
    logic          w_full;
    logic          w_pop;
    logic          w_empty;
    tspf_pkg::t_op w_push_op;
    tspf_pkg::t_op w_head_op;

    tspf_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_tick     (i_tick),
        .o_push     (w_push),
        .o_op       (w_push_op),
        .i_full     (w_full)
    );

    tspf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_op    (w_push_op),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_empty (w_empty),
        .o_op    (w_head_op)
    );

    tspf_back #(
        .PHASES (PHASES_PER_SLOT),
        .SLOTS  (SLOTS_PER_FRAME)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (w_empty),
        .i_op    (w_head_op),
        .o_pop   (w_pop),
        .o_res   (o_res)
    );

endmodule
